// ----- design/msm_pkg.sv -----
// Shared constants, types and helpers for the multi-rule string matcher.
`timescale 1ns / 1ps

package msm_pkg;

	localparam int RULE_SLOTS = 8;
	localparam int TARGET_MAX = 16;
	localparam int CHAR_WIDTH = 16;

	// Field widths of the input item
	localparam int OP_W   = 2;
	localparam int SLOT_W = 3;
	localparam int POS_W  = $clog2(TARGET_MAX);
	localparam int LEN_W  = $clog2(TARGET_MAX + 1);
	localparam int MODE_W = 3;
	localparam int ACT_W  = 4;
	localparam int SEEN_W = 5;

	localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

	// Opcodes
	typedef enum logic [OP_W-1:0] {
		OP_STORE = 2'd0,
		OP_SET   = 2'd1,
		OP_MATCH = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	// Mode bits
	localparam int MODE_BEGIN_BIT    = 0;
	localparam int MODE_END_BIT      = 1;
	localparam int MODE_CONTAINS_BIT = 2;

	// Per-character control broadcast to every rule chain
	typedef struct packed {
		logic                  step;     // match character transfer
		logic                  first;    // first character of a string
		logic                  fold_on;  // case folding for this string
		logic [CHAR_WIDTH-1:0] val_char; // value character, already folded
		logic [SEEN_W-1:0]     seen;     // characters seen before this one
	} step_t;

	// Per-rule status after the current character
	typedef struct packed {
		logic              hit;   // Shift-And bit at length-1 after update
		logic              alive; // prefix still matching after update
		logic [LEN_W-1:0]  len;
		logic [MODE_W-1:0] mode;
	} rule_stat_t;

	// Fold ASCII A-Z to a-z
	function automatic logic [CHAR_WIDTH-1:0] fold_char(
		input logic [CHAR_WIDTH-1:0] c,
		input logic                  on
	);
		logic [CHAR_WIDTH-1:0] r;
		r = c;
		if (on && c >= CHAR_WIDTH'(8'h41) && c <= CHAR_WIDTH'(8'h5A))
			r = c + CHAR_WIDTH'(8'h20);
		return r;
	endfunction

endpackage

// ----- design/multi_rule_string_matcher_core.sv -----
// Top level of the multi-rule string matcher: stream control, rule chains, result register.
`timescale 1ns / 1ps

// Usage:
//   Input stream (s_axis_*): every transfer is one item. Store items load a target
//   character into a rule cell, set items give a rule its length and mode, match
//   items carry one value character; tlast marks the last character of a string.
//   Output stream (m_axis_*): one transfer per finished string, matched in bit 0.
//   Config channel (cfg_*): writes active_rules; always ready, write only when idle.
// Result: the result of a last character appears on m_axis in the cycle after its
//   input transfer. Throughput: one item per cycle while s_axis_tready is high; all
//   eight rule chains of sixteen cells compare the character in parallel.
// Stall: the result sits in the output register; the input side keeps accepting
//   while that register is empty or is being drained in the same cycle.
// Reset: rules disabled with length zero, active_rules zero, no string in
//   progress; target characters hold nothing defined until stored.
module multi_rule_string_matcher_core (
	input  logic        clk,
	input  logic        arst_n,
	// tdata: opcode[1:0], rule_index[4:2], position[8:5], char_code[24:9],
	//        rule_length[29:25], rule_mode[32:30], ignore_case[33]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic        s_axis_tlast,   // last_char
	// tdata: matched[0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,
	// active_rules[3:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	localparam int RS = msm_pkg::RULE_SLOTS;
	localparam int CW = msm_pkg::CHAR_WIDTH;

	logic [msm_pkg::OP_W-1:0]   in_opcode;
	logic [msm_pkg::SLOT_W-1:0] in_slot;
	logic [msm_pkg::POS_W-1:0]  in_pos;
	logic [CW-1:0]              in_char;
	logic [msm_pkg::LEN_W-1:0]  in_len;
	logic [msm_pkg::MODE_W-1:0] in_mode;
	logic                       in_ic;

	logic                       in_xfer;
	logic                       do_store;
	logic                       do_set;
	logic                       do_match;
	logic                       fold_now;
	logic [msm_pkg::SEEN_W-1:0] seen_next;
	logic                       hit_next;
	logic                       matched;

	logic [msm_pkg::ACT_W-1:0]  active_rules_q;
	logic [msm_pkg::SEEN_W-1:0] seen_q;
	logic                       hit_q;
	logic                       fold_q;
	logic                       out_valid_q;
	logic                       matched_q;

	msm_pkg::step_t      stp;
	msm_pkg::rule_stat_t stat [RS];
	logic [RS-1:0]       rule_on;
	logic [RS-1:0]       contains_hit;
	logic [RS-1:0]       final_hit;

	// Unpack the input item
	assign in_opcode = s_axis_tdata[1:0];
	assign in_slot   = s_axis_tdata[4:2];
	assign in_pos    = s_axis_tdata[8:5];
	assign in_char   = s_axis_tdata[24:9];
	assign in_len    = s_axis_tdata[29:25];
	assign in_mode   = s_axis_tdata[32:30];
	assign in_ic     = s_axis_tdata[33];

	// Handshake
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign do_store = in_xfer && (in_opcode == msm_pkg::OP_STORE);
	assign do_set   = in_xfer && (in_opcode == msm_pkg::OP_SET);
	assign do_match = in_xfer && (in_opcode == msm_pkg::OP_MATCH);
	assign cfg_ready = 1'b1;

	// Character broadcast to the chains
	assign fold_now     = (seen_q == '0) ? in_ic : fold_q;
	assign stp.step     = do_match;
	assign stp.first    = (seen_q == '0);
	assign stp.fold_on  = fold_now;
	assign stp.val_char = msm_pkg::fold_char(in_char, fold_now);
	assign stp.seen     = seen_q;

	// Rule chains
	for (genvar r = 0; r < RS; r++) begin : g_rule
		msm_rule u_rule (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (do_store && (in_slot == msm_pkg::SLOT_W'(r))),
			.wr_pos   (in_pos),
			.wr_char  (in_char),
			.set_en   (do_set && (in_slot == msm_pkg::SLOT_W'(r))),
			.set_len  (in_len),
			.set_mode (in_mode),
			.stp      (stp),
			.stat     (stat[r])
		);

		assign rule_on[r] = int'(active_rules_q) > r;
		assign contains_hit[r] = rule_on[r] && stat[r].mode[msm_pkg::MODE_CONTAINS_BIT]
			&& stat[r].hit;
		// Final check of one rule on the last character
		assign final_hit[r] = rule_on[r] && (stat[r].mode != '0) && (
			(stat[r].len == '0) ||
			(stat[r].mode[msm_pkg::MODE_BEGIN_BIT] && stat[r].alive &&
				(seen_next >= msm_pkg::SEEN_W'(stat[r].len))) ||
			(stat[r].mode[msm_pkg::MODE_END_BIT] && stat[r].hit));
	end

	assign seen_next = (seen_q == msm_pkg::SEEN_MAX) ? seen_q
		: seen_q + msm_pkg::SEEN_W'(1);
	assign hit_next  = (stp.first ? 1'b0 : hit_q) | (|contains_hit);
	assign matched   = hit_next | (|final_hit);

	// String progress and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_rules_q <= '0;
			seen_q         <= '0;
			hit_q          <= 1'b0;
			fold_q         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				active_rules_q <= cfg_data;
			if (do_match) begin
				fold_q <= fold_now;
				if (s_axis_tlast) begin
					seen_q <= '0;
					hit_q  <= 1'b0;
				end else begin
					seen_q <= seen_next;
					hit_q  <= hit_next;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_match && s_axis_tlast) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_match && s_axis_tlast)
			matched_q <= matched;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, matched_q};

endmodule

// ----- design/msm_cell.sv -----
// One character cell of a rule chain: target character, comparator, Shift-And bit.
`timescale 1ns / 1ps

module msm_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [msm_pkg::CHAR_WIDTH-1:0]  wr_char,
	input  msm_pkg::step_t                  stp,
	input  logic                            enable,   // cell lies within target length
	input  logic                            link_in,  // Shift-And bit from left neighbor
	output logic                            eq,
	output logic                            bit_next,
	output logic                            bit_q
);

	logic [msm_pkg::CHAR_WIDTH-1:0] target_q;

	// Target character, undefined until written
	always_ff @(posedge clk) begin
		if (wr_en)
			target_q <= wr_char;
	end

	// Compare against the folded value character
	assign eq = enable && (msm_pkg::fold_char(target_q, stp.fold_on) == stp.val_char);
	assign bit_next = link_in & eq;

	// Shift-And bit, handed to the right neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (stp.step) begin
			bit_q <= bit_next;
		end
	end

endmodule

// ----- design/msm_rule.sv -----
// One rule: length, mode, prefix-alive flag and a chain of character cells.
`timescale 1ns / 1ps

module msm_rule (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [msm_pkg::POS_W-1:0]       wr_pos,
	input  logic [msm_pkg::CHAR_WIDTH-1:0]  wr_char,
	input  logic                            set_en,
	input  logic [msm_pkg::LEN_W-1:0]       set_len,
	input  logic [msm_pkg::MODE_W-1:0]      set_mode,
	input  msm_pkg::step_t                  stp,
	output msm_pkg::rule_stat_t             stat
);

	localparam int TM = msm_pkg::TARGET_MAX;

	logic [msm_pkg::LEN_W-1:0]  len_q;
	logic [msm_pkg::MODE_W-1:0] mode_q;
	logic                       alive_q;

	logic [TM-1:0] cell_en;
	logic [TM-1:0] eq;
	logic [TM-1:0] bit_next;
	logic [TM-1:0] bit_q;
	logic [TM-1:0] link;
	logic [TM-1:0] kill;
	logic [msm_pkg::POS_W-1:0] len_m1;
	logic alive_next;

	// Chain of cells; the head always sees a match start
	for (genvar i = 0; i < TM; i++) begin : g_cell
		assign cell_en[i] = len_q > msm_pkg::LEN_W'(i);
		if (i == 0) begin : g_head
			assign link[i] = 1'b1;
		end else begin : g_body
			assign link[i] = stp.first ? 1'b0 : bit_q[i-1];
		end
		assign kill[i] = cell_en[i] && (stp.seen == msm_pkg::SEEN_W'(i)) && !eq[i];

		msm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wr_en    (wr_en && (wr_pos == msm_pkg::POS_W'(i))),
			.wr_char  (wr_char),
			.stp      (stp),
			.enable   (cell_en[i]),
			.link_in  (link[i]),
			.eq       (eq[i]),
			.bit_next (bit_next[i]),
			.bit_q    (bit_q[i])
		);
	end

	// Prefix check: the cell at the current position must match
	assign alive_next = (stp.first | alive_q) & ~(|kill);

	// Length and mode; prefix flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			mode_q  <= '0;
			alive_q <= 1'b1;
		end else begin
			if (set_en) begin
				len_q  <= (set_len > msm_pkg::LEN_W'(TM)) ? msm_pkg::LEN_W'(TM) : set_len;
				mode_q <= set_mode;
			end
			if (stp.step)
				alive_q <= alive_next;
		end
	end

	// Status: bit at length-1 of the updated vector
	assign len_m1     = msm_pkg::POS_W'(len_q - msm_pkg::LEN_W'(1));
	assign stat.hit   = (len_q != '0) && bit_next[len_m1];
	assign stat.alive = alive_next;
	assign stat.len   = len_q;
	assign stat.mode  = mode_q;

endmodule

// ----- sim/tb.sv -----
// Testbench for multi_rule_string_matcher_core: directed and random traffic checked by a scoreboard.
`timescale 1ns / 1ps

module tb;

	localparam int IDLE_LIMIT  = 2000;
	localparam int PHASE_ITEMS = 317;
	localparam int CFG_EVERY   = 100;

	// Predicts the matched flag of each finished string from the accepted transfers
	class match_scoreboard;
		bit [msm_pkg::CHAR_WIDTH-1:0] tgt [msm_pkg::RULE_SLOTS][msm_pkg::TARGET_MAX];
		bit [msm_pkg::LEN_W-1:0]      lens [msm_pkg::RULE_SLOTS];
		bit [msm_pkg::MODE_W-1:0]     modes [msm_pkg::RULE_SLOTS];
		bit [msm_pkg::TARGET_MAX-1:0] shift_vec [msm_pkg::RULE_SLOTS];
		bit                           alive [msm_pkg::RULE_SLOTS];
		bit [msm_pkg::SEEN_W-1:0]     seen;
		bit                           hit;
		bit                           fold_on;
		bit [msm_pkg::ACT_W-1:0]      active;
		bit                           match_q [$];
		int                           errors;

		function new();
			for (int r = 0; r < msm_pkg::RULE_SLOTS; r++) begin
				lens[r] = '0;
				modes[r] = '0;
				shift_vec[r] = '0;
				alive[r] = 1'b1;
				for (int p = 0; p < msm_pkg::TARGET_MAX; p++)
					tgt[r][p] = '0;
			end
			seen = '0;
			hit = 1'b0;
			fold_on = 1'b0;
			active = '0;
			errors = 0;
		endfunction

		function bit [msm_pkg::CHAR_WIDTH-1:0] to_lower(bit [msm_pkg::CHAR_WIDTH-1:0] c,
				bit on);
			if (on && c >= 16'h41 && c <= 16'h5A)
				return c + 16'h20;
			return c;
		endfunction

		function void set_rules(bit [msm_pkg::ACT_W-1:0] v);
			active = v;
		endfunction

		function int pending();
			return match_q.size();
		endfunction

		// One accepted input transfer
		function void note_item(bit [msm_pkg::OP_W-1:0] op, bit [msm_pkg::SLOT_W-1:0] slot,
				bit [msm_pkg::POS_W-1:0] pos, bit [msm_pkg::CHAR_WIDTH-1:0] ch,
				bit [msm_pkg::LEN_W-1:0] ln, bit [msm_pkg::MODE_W-1:0] md,
				bit ic, bit last);
			bit [msm_pkg::CHAR_WIDTH-1:0] c;
			bit [msm_pkg::TARGET_MAX-1:0] eq;
			int n;
			int len_r;
			bit m;
			case (msm_pkg::opcode_t'(op))
				msm_pkg::OP_STORE: begin
					tgt[slot][pos] = ch;
				end
				msm_pkg::OP_SET: begin
					lens[slot] = (ln > msm_pkg::TARGET_MAX) ?
						msm_pkg::LEN_W'(msm_pkg::TARGET_MAX) : ln;
					modes[slot] = md;
				end
				msm_pkg::OP_MATCH: begin
					// new string: latch folding, clear the per-rule trackers
					if (seen == 0) begin
						fold_on = ic;
						hit = 1'b0;
						for (int r = 0; r < msm_pkg::RULE_SLOTS; r++) begin
							shift_vec[r] = '0;
							alive[r] = 1'b1;
						end
					end
					c = to_lower(ch, fold_on);
					n = (active > msm_pkg::RULE_SLOTS) ? msm_pkg::RULE_SLOTS : active;
					for (int r = 0; r < msm_pkg::RULE_SLOTS; r++) begin
						len_r = lens[r];
						eq = '0;
						for (int i = 0; i < len_r; i++)
							if (to_lower(tgt[r][i], fold_on) == c)
								eq[i] = 1'b1;
						shift_vec[r] = ((shift_vec[r] << 1) | 1) & eq;
						if (seen < len_r && !eq[seen])
							alive[r] = 1'b0;
						if (r < n && len_r > 0 && modes[r][msm_pkg::MODE_CONTAINS_BIT] &&
								shift_vec[r][len_r-1])
							hit = 1'b1;
					end
					if (seen < msm_pkg::SEEN_MAX)
						seen++;
					if (last) begin
						m = hit;
						for (int r = 0; r < n; r++) begin
							len_r = lens[r];
							if (modes[r] != 0) begin
								if (len_r == 0) begin
									m = 1'b1;
								end else begin
									if (modes[r][msm_pkg::MODE_BEGIN_BIT] && alive[r] &&
											seen >= len_r)
										m = 1'b1;
									if (modes[r][msm_pkg::MODE_END_BIT] &&
											shift_vec[r][len_r-1])
										m = 1'b1;
								end
							end
						end
						seen = '0;
						hit = 1'b0;
						match_q.push_back(m);
					end
				end
				default: ;
			endcase
		endfunction

		// One accepted output transfer
		function void check_result(bit got);
			bit want;
			if (match_q.size() == 0) begin
				$error("matched: no result expected, actual %0d", got);
				errors++;
			end else begin
				want = match_q.pop_front();
				if (want != got) begin
					$error("matched: expected %0d, actual %0d", want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data = '0;

	match_scoreboard sb = new();

	// Stimulus-side copy of the targets, so strings can embed them and no unwritten cell is read
	bit                           written [msm_pkg::RULE_SLOTS][msm_pkg::TARGET_MAX];
	bit [msm_pkg::CHAR_WIDTH-1:0] gen_tgt [msm_pkg::RULE_SLOTS][msm_pkg::TARGET_MAX];
	int                           gen_len [msm_pkg::RULE_SLOTS];
	int                           item_count = 0;
	int                           tx_idle_pct = 0;
	int                           rx_idle_pct = 0;
	int                           idle_cycles = 0;

	multi_rule_string_matcher_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		// tdata: opcode, rule_index, position, char_code, rule_length, rule_mode, ignore_case
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		// tdata: matched
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Receiver backpressure
	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
	end

	// Monitor: results are checked before the same edge's input is noted
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata[0]);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_item(s_axis_tdata[1:0], s_axis_tdata[4:2], s_axis_tdata[8:5],
					s_axis_tdata[24:9], s_axis_tdata[29:25], s_axis_tdata[32:30],
					s_axis_tdata[33], s_axis_tlast);
			if (cfg_valid && cfg_ready)
				sb.set_rules(cfg_data);
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [39:0] pack_item(msm_pkg::opcode_t op,
			bit [msm_pkg::SLOT_W-1:0] slot, bit [msm_pkg::POS_W-1:0] pos,
			bit [msm_pkg::CHAR_WIDTH-1:0] ch, bit [msm_pkg::LEN_W-1:0] ln,
			bit [msm_pkg::MODE_W-1:0] md, bit ic);
		return {6'b0, ic, md, ln, ch, pos, slot, op};
	endfunction

	function automatic bit [msm_pkg::CHAR_WIDTH-1:0] pick_char();
		int r;
		bit [msm_pkg::CHAR_WIDTH-1:0] abc [8] = '{16'h61, 16'h62, 16'h63, 16'h41, 16'h42,
			16'h43, 16'h5A, 16'h7A};
		r = $urandom_range(0, 99);
		if (r < 70)
			return abc[$urandom_range(0, 7)];
		if (r < 85)
			return msm_pkg::CHAR_WIDTH'($urandom_range(16'h20, 16'h7E));
		return msm_pkg::CHAR_WIDTH'($urandom_range(0, 16'hFFFF));
	endfunction

	// Input transfer with random leading gaps
	task automatic push_item(logic [39:0] d, bit l);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic store_char(int slot, int pos, bit [msm_pkg::CHAR_WIDTH-1:0] ch);
		written[slot][pos] = 1'b1;
		gen_tgt[slot][pos] = ch;
		item_count++;
		push_item(pack_item(msm_pkg::OP_STORE, msm_pkg::SLOT_W'(slot), msm_pkg::POS_W'(pos),
			ch, msm_pkg::LEN_W'($urandom_range(0, 31)),
			msm_pkg::MODE_W'($urandom_range(0, 7)), bit'($urandom_range(0, 1))),
			bit'($urandom_range(0, 1)));
	endtask

	task automatic set_rule(int slot, int ln, int md);
		gen_len[slot] = (ln > msm_pkg::TARGET_MAX) ? msm_pkg::TARGET_MAX : ln;
		item_count++;
		push_item(pack_item(msm_pkg::OP_SET, msm_pkg::SLOT_W'(slot),
			msm_pkg::POS_W'($urandom_range(0, 15)),
			msm_pkg::CHAR_WIDTH'($urandom_range(0, 16'hFFFF)), msm_pkg::LEN_W'(ln),
			msm_pkg::MODE_W'(md), bit'($urandom_range(0, 1))),
			bit'($urandom_range(0, 1)));
	endtask

	task automatic match_char(bit [msm_pkg::CHAR_WIDTH-1:0] ch, bit ic, bit last);
		item_count++;
		push_item(pack_item(msm_pkg::OP_MATCH, msm_pkg::SLOT_W'($urandom_range(0, 7)),
			msm_pkg::POS_W'($urandom_range(0, 15)), ch, msm_pkg::LEN_W'($urandom_range(0, 31)),
			msm_pkg::MODE_W'($urandom_range(0, 7)), ic), last);
	endtask

	// Unused opcode with random fields; not counted as an item
	task automatic send_noise();
		push_item({6'b0, 32'($urandom), msm_pkg::OP_NONE}, bit'($urandom_range(0, 1)));
	endtask

	task automatic random_store();
		store_char($urandom_range(0, msm_pkg::RULE_SLOTS - 1),
			$urandom_range(0, msm_pkg::TARGET_MAX - 1), pick_char());
	endtask

	// New length and mode; missing target cells are stored first
	task automatic random_set();
		int slot;
		int r;
		int ln;
		int eff;
		slot = $urandom_range(0, msm_pkg::RULE_SLOTS - 1);
		r = $urandom_range(0, 99);
		if (r < 15)
			ln = 0;
		else if (r < 80)
			ln = $urandom_range(1, 5);
		else if (r < 90)
			ln = $urandom_range(6, msm_pkg::TARGET_MAX);
		else
			ln = $urandom_range(msm_pkg::TARGET_MAX + 1, 31);
		eff = (ln > msm_pkg::TARGET_MAX) ? msm_pkg::TARGET_MAX : ln;
		for (int p = 0; p < eff; p++)
			if (!written[slot][p])
				store_char(slot, p, pick_char());
		set_rule(slot, ln, $urandom_range(0, 7));
	endtask

	// One value string, often built around a stored target with random case
	task automatic send_string();
		bit [msm_pkg::CHAR_WIDTH-1:0] vals [$];
		bit [msm_pkg::CHAR_WIDTH-1:0] c;
		int n;
		int r;
		int slot;
		int tl;
		int at;
		bit ic;
		r = $urandom_range(0, 99);
		if (r < 85)
			n = $urandom_range(1, 8);
		else if (r < 97)
			n = $urandom_range(9, 20);
		else
			n = $urandom_range(32, 40);
		for (int k = 0; k < n; k++)
			vals.push_back(pick_char());
		if ($urandom_range(0, 99) < 60) begin
			slot = $urandom_range(0, msm_pkg::RULE_SLOTS - 1);
			tl = gen_len[slot];
			while (vals.size() < tl)
				vals.push_back(pick_char());
			n = vals.size();
			case ($urandom_range(0, 2))
				0: at = 0;
				1: at = n - tl;
				default: at = $urandom_range(0, n - tl);
			endcase
			for (int k = 0; k < tl; k++) begin
				c = gen_tgt[slot][k];
				if (((c >= 16'h41 && c <= 16'h5A) || (c >= 16'h61 && c <= 16'h7A)) &&
						$urandom_range(0, 99) < 30)
					c = c ^ 16'h20;
				vals[at + k] = c;
			end
		end
		ic = bit'($urandom_range(0, 1));
		for (int k = 0; k < n; k++) begin
			// occasional rule change between characters
			if ($urandom_range(0, 99) < 3) begin
				if ($urandom_range(0, 1))
					random_set();
				else
					random_store();
			end
			match_char(vals[k], (k == 0) ? ic : bit'($urandom_range(0, 1)), k == n - 1);
		end
	endtask

	// Hold off input until all results are in, let the pipeline empty, then write the register
	task automatic settle_and_write(bit [msm_pkg::ACT_W-1:0] v);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic bit [msm_pkg::ACT_W-1:0] pick_rules();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return msm_pkg::ACT_W'($urandom_range(msm_pkg::RULE_SLOTS + 1, 15));
		return msm_pkg::ACT_W'($urandom_range(1, msm_pkg::RULE_SLOTS));
	endfunction

	task automatic run_phase(int items, int tx_pct, int rx_pct,
			bit [msm_pkg::ACT_W-1:0] first_cfg);
		int start;
		int next_cfg;
		int r;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		settle_and_write(first_cfg);
		start = item_count;
		next_cfg = start + CFG_EVERY;
		while (item_count - start < items) begin
			if (item_count >= next_cfg) begin
				settle_and_write(pick_rules());
				next_cfg += CFG_EVERY;
			end
			r = $urandom_range(0, 99);
			if (r < 8)
				random_set();
			else if (r < 16)
				random_store();
			else if (r < 19)
				send_noise();
			else
				send_string();
		end
	endtask

	initial begin
		for (int r = 0; r < msm_pkg::RULE_SLOTS; r++) begin
			gen_len[r] = 0;
			for (int p = 0; p < msm_pkg::TARGET_MAX; p++) begin
				written[r][p] = 1'b0;
				gen_tgt[r][p] = '0;
			end
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: folding, begins/ends/contains, edits inside a string, empty target
		settle_and_write(msm_pkg::ACT_W'(msm_pkg::RULE_SLOTS));
		store_char(0, 0, 16'h41);
		store_char(0, 1, 16'h62);
		set_rule(0, 2, 1 << msm_pkg::MODE_BEGIN_BIT);
		match_char(16'h61, 1'b1, 1'b0);
		match_char(16'h42, 1'b0, 1'b0);
		match_char(16'h78, 1'b0, 1'b1);
		match_char(16'h61, 1'b0, 1'b0);
		match_char(16'h62, 1'b1, 1'b1);
		set_rule(0, 2, (1 << msm_pkg::MODE_END_BIT) | (1 << msm_pkg::MODE_CONTAINS_BIT));
		match_char(16'h78, 1'b0, 1'b0);
		match_char(16'h41, 1'b0, 1'b0);
		match_char(16'h62, 1'b0, 1'b1);
		push_item({6'b0, 32'hFFFF_FFFF, msm_pkg::OP_NONE}, 1'b1);
		store_char(msm_pkg::RULE_SLOTS - 1, msm_pkg::TARGET_MAX - 1, 16'hFFFF);
		store_char(msm_pkg::RULE_SLOTS - 1, 0, 16'h0000);
		set_rule(msm_pkg::RULE_SLOTS - 1, 0, 0);
		match_char(16'h41, 1'b0, 1'b0);
		set_rule(0, 2, 1 << msm_pkg::MODE_CONTAINS_BIT);
		match_char(16'h62, 1'b0, 1'b0);
		match_char(16'hFFFF, 1'b0, 1'b1);
		set_rule(msm_pkg::RULE_SLOTS - 1, 0, 7);
		match_char(16'h0000, 1'b1, 1'b1);
		set_rule(msm_pkg::RULE_SLOTS - 1, 0, 0);
		// no active rules, then a register value above the slot count
		settle_and_write('0);
		match_char(16'h41, 1'b0, 1'b1);
		settle_and_write('1);
		match_char(16'h41, 1'b0, 1'b0);
		match_char(16'h62, 1'b0, 1'b1);

		// Random phases with different idling on each side
		run_phase(PHASE_ITEMS, 18, 46, msm_pkg::ACT_W'(msm_pkg::RULE_SLOTS));
		run_phase(PHASE_ITEMS, 46, 18, '1);
		run_phase(PHASE_ITEMS - 1, 0, 0,
			msm_pkg::ACT_W'($urandom_range(1, msm_pkg::RULE_SLOTS - 1)));

		// Drain
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- multi_rule_string_matcher_core.f -----
design/msm_pkg.sv
design/msm_cell.sv
design/msm_rule.sv
design/multi_rule_string_matcher_core.sv
sim/tb.sv
